@@ src/fully_connected_layer_unit_assert.svh @@
// Assertion macros for the fully connected layer unit.
// Used by the top level; needs aclk and aresetn in scope.
`ifndef FULLY_CONNECTED_LAYER_UNIT_ASSERT_SVH
`define FULLY_CONNECTED_LAYER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fcl_pkg.sv @@
// Shared types and constants for the fully connected layer unit.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fcl_pkg;

    localparam int DEF_MAX_ROWS  = 16;
    localparam int DEF_MAX_INNER = 16;
    localparam int DEF_MAX_COLS  = 16;

    localparam int ACTION_W = 2;
    localparam int IDX_W    = 4;
    localparam int DATA_W   = 16;
    localparam int OUT_W    = 32;
    localparam int ACC_W    = 40;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_USED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_USED  = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WR_INPUT  = 2'd0,
        ACT_WR_WEIGHT = 2'd1,
        ACT_WR_BIAS   = 2'd2,
        ACT_READ      = 2'd3
    } action_t;

    typedef struct packed {
        logic             wr_en;  // write the element of the accepted transaction
        logic             start;  // latch row/col and clear the accumulator
        logic             issue;  // read the stores at inner position k
        logic [CFG_W-1:0] k;
        logic             load;   // saturate and load the output register
    } cmd_t;

endpackage

`default_nettype wire

@@ src/fcl_ctrl.sv @@
// Controller for the fully connected layer unit: config registers and sequencing FSM.
// Depends on fcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcl_ctrl #(
    parameter int MAX_ROWS  = fcl_pkg::DEF_MAX_ROWS,
    parameter int MAX_INNER = fcl_pkg::DEF_MAX_INNER,
    parameter int MAX_COLS  = fcl_pkg::DEF_MAX_COLS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [fcl_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [fcl_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [fcl_pkg::ACTION_W-1:0]   s_action,
    input  logic [fcl_pkg::IDX_W-1:0]      s_row,
    input  logic [fcl_pkg::IDX_W-1:0]      s_col,
    output logic                           m_valid,
    input  logic                           m_ready,
    output fcl_pkg::cmd_t                  cmd
);
    import fcl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] k_reg, k_next;
    logic             drain_reg, drain_next;
    logic             m_valid_reg, m_valid_next;
    logic [CFG_W-1:0] rows_reg, rows_next;
    logic [CFG_W-1:0] inner_reg, inner_next;
    logic [CFG_W-1:0] cols_reg, cols_next;
    logic             accept;
    logic             in_range;
    logic             out_free;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int bound);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (int'(v) > bound) begin
            r = CFG_W'(bound);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign in_range = ({1'b0, s_row} < rows_reg) && ({1'b0, s_col} < cols_reg);
    assign out_free = !m_valid_reg || m_ready;

    // Config registers hold the clamped size
    always_comb begin
        rows_next  = rows_reg;
        inner_next = inner_reg;
        cols_next  = cols_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ROWS_USED:  rows_next  = clamp_size(cfg_wdata, MAX_ROWS);
                REG_INNER_USED: inner_next = clamp_size(cfg_wdata, MAX_INNER);
                REG_COLS_USED:  cols_next  = clamp_size(cfg_wdata, MAX_COLS);
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        drain_next   = drain_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.k        = k_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_action != ACT_READ) begin
                        cmd.wr_en = 1'b1;
                    end else if (in_range) begin
                        cmd.start  = 1'b1;
                        k_next     = '0;
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN: begin
                cmd.issue = 1'b1;
                if (k_reg == inner_reg - CFG_W'(1)) begin
                    drain_next = 1'b0;
                    state_next = S_DRAIN;
                end else begin
                    k_next = k_reg + CFG_W'(1);
                end
            end
            S_DRAIN: begin
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            drain_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            rows_reg    <= clamp_size(CFG_W'(16), MAX_ROWS);
            inner_reg   <= clamp_size(CFG_W'(16), MAX_INNER);
            cols_reg    <= clamp_size(CFG_W'(16), MAX_COLS);
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            drain_reg   <= drain_next;
            m_valid_reg <= m_valid_next;
            rows_reg    <= rows_next;
            inner_reg   <= inner_next;
            cols_reg    <= cols_next;
        end
    end

endmodule

`default_nettype wire

@@ src/fcl_datapath.sv @@
// Datapath for the fully connected layer unit: three element stores, MAC pipeline, saturation.
// Depends on fcl_pkg; driven by fcl_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module fcl_datapath #(
    parameter int MAX_ROWS  = fcl_pkg::DEF_MAX_ROWS,
    parameter int MAX_INNER = fcl_pkg::DEF_MAX_INNER,
    parameter int MAX_COLS  = fcl_pkg::DEF_MAX_COLS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fcl_pkg::cmd_t                       cmd,
    input  logic [fcl_pkg::ACTION_W-1:0]        s_action,
    input  logic [fcl_pkg::IDX_W-1:0]           s_row,
    input  logic [fcl_pkg::IDX_W-1:0]           s_col,
    input  logic signed [fcl_pkg::DATA_W-1:0]   s_element_value,
    output logic signed [fcl_pkg::OUT_W-1:0]    m_out_value,
    output logic                                m_saturated
);
    import fcl_pkg::*;

    localparam int IN_DEPTH = MAX_ROWS * MAX_INNER;
    localparam int W_DEPTH  = MAX_INNER * MAX_COLS;
    localparam int B_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int IN_AW    = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int W_AW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int B_AW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

    logic signed [DATA_W-1:0] in_mem [IN_DEPTH];
    logic signed [DATA_W-1:0] w_mem  [W_DEPTH];
    logic signed [DATA_W-1:0] b_mem  [B_DEPTH];

    logic [IDX_W-1:0]          row_reg;
    logic [IDX_W-1:0]          col_reg;
    logic signed [DATA_W-1:0]  in_rd_reg;
    logic signed [DATA_W-1:0]  w_rd_reg;
    logic signed [DATA_W-1:0]  b_rd_reg;
    logic                      rd_v_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic                      prod_v_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [OUT_W-1:0]   out_reg;
    logic                      sat_reg;

    logic [IN_AW-1:0] in_wa, in_ra;
    logic [W_AW-1:0]  w_wa, w_ra;
    logic [B_AW-1:0]  b_wa, b_ra;
    logic             in_wr_ok, w_wr_ok, b_wr_ok;
    logic signed [ACC_W-1:0] bias_ext;
    logic signed [ACC_W-1:0] sum;
    logic             sum_fits;

    // Row-major addressing, each store at its own parameter bounds
    assign in_wa = IN_AW'(int'(s_row) * MAX_INNER + int'(s_col));
    assign w_wa  = W_AW'(int'(s_row) * MAX_COLS + int'(s_col));
    assign b_wa  = B_AW'(int'(s_row) * MAX_COLS + int'(s_col));
    assign in_ra = IN_AW'(int'(row_reg) * MAX_INNER + int'(cmd.k));
    assign w_ra  = W_AW'(int'(cmd.k) * MAX_COLS + int'(col_reg));
    assign b_ra  = B_AW'(int'(row_reg) * MAX_COLS + int'(col_reg));

    // Drop writes beyond the store bounds
    assign in_wr_ok = (int'(s_row) < MAX_ROWS)  && (int'(s_col) < MAX_INNER);
    assign w_wr_ok  = (int'(s_row) < MAX_INNER) && (int'(s_col) < MAX_COLS);
    assign b_wr_ok  = (int'(s_row) < MAX_ROWS)  && (int'(s_col) < MAX_COLS);

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && (s_action == ACT_WR_INPUT) && in_wr_ok) begin
            in_mem[in_wa] <= s_element_value;
        end
        if (cmd.issue) begin
            in_rd_reg <= in_mem[in_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && (s_action == ACT_WR_WEIGHT) && w_wr_ok) begin
            w_mem[w_wa] <= s_element_value;
        end
        if (cmd.issue) begin
            w_rd_reg <= w_mem[w_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && (s_action == ACT_WR_BIAS) && b_wr_ok) begin
            b_mem[b_wa] <= s_element_value;
        end
        if (cmd.issue) begin
            b_rd_reg <= b_mem[b_ra];
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (cmd.start) begin
            acc_next = '0;
        end else if (prod_v_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // Bias widens to Q16.16; clip when the upper bits are not a sign run
    assign bias_ext = ACC_W'($signed({b_rd_reg, 8'h00}));
    assign sum      = acc_reg + bias_ext;
    assign sum_fits = (&sum[ACC_W-1:OUT_W-1]) || !(|sum[ACC_W-1:OUT_W-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end else begin
            rd_v_reg   <= cmd.issue;
            prod_v_reg <= rd_v_reg;
        end
        if (cmd.start) begin
            row_reg <= s_row;
            col_reg <= s_col;
        end
        prod_reg <= in_rd_reg * w_rd_reg;
        acc_reg  <= acc_next;
        if (cmd.load) begin
            sat_reg <= !sum_fits;
            if (sum_fits) begin
                out_reg <= sum[OUT_W-1:0];
            end else if (sum[ACC_W-1]) begin
                out_reg <= {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                out_reg <= {1'b0, {(OUT_W-1){1'b1}}};
            end
        end
    end

    assign m_out_value = out_reg;
    assign m_saturated = sat_reg;

endmodule

`default_nettype wire

@@ src/fully_connected_layer_unit.sv @@
// Top level of the fully connected layer unit: out = in x weight + bias, one element per read.
// Depends on fcl_pkg, fcl_ctrl, fcl_datapath and fully_connected_layer_unit_assert.svh.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_action, s_row, s_col, s_element_value
//  m_       out        m_valid / m_ready    m_out_value, m_saturated
//  cfg_     in         cfg_wr_en            cfg_addr, cfg_wdata
//
// A write transaction (input, weight or bias element) and a read out of range are accepted
// without leaving S_IDLE. A read in range closes the input from acceptance through S_RUN
// (inner_used MAC issues), S_DRAIN (drain multiply and accumulate) and S_DONE (saturate),
// so no new transaction is accepted until that read has finished.
// Reset is synchronous, active low. The result waits in an output register; writes keep
// flowing meanwhile, and a later read holds in its final cycle until that register is free.
`timescale 1ns / 1ps
`default_nettype none

`include "fully_connected_layer_unit_assert.svh"

module fully_connected_layer_unit #(
    parameter int MAX_ROWS  = fcl_pkg::DEF_MAX_ROWS,
    parameter int MAX_INNER = fcl_pkg::DEF_MAX_INNER,
    parameter int MAX_COLS  = fcl_pkg::DEF_MAX_COLS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [fcl_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [fcl_pkg::CFG_W-1:0]           cfg_wdata,
    // element transactions
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fcl_pkg::ACTION_W-1:0]        s_action,
    input  logic [fcl_pkg::IDX_W-1:0]           s_row,
    input  logic [fcl_pkg::IDX_W-1:0]           s_col,
    input  logic signed [fcl_pkg::DATA_W-1:0]   s_element_value,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fcl_pkg::OUT_W-1:0]    m_out_value,
    output logic                                m_saturated
);
    import fcl_pkg::*;

    cmd_t cmd;

    // Sequencer: config registers, range check, inner-loop counter, result valid
    fcl_ctrl #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_row     (s_row),
        .s_col     (s_col),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    // Stores, multiply-accumulate pipeline and saturating output register
    fcl_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_action        (s_action),
        .s_row           (s_row),
        .s_col           (s_col),
        .s_element_value (s_element_value),
        .m_out_value     (m_out_value),
        .m_saturated     (m_saturated)
    );

    // A result must never overwrite one that has not been taken
    `FCL_ASSERT_NOW(a_load_into_free, cmd.load, (!m_valid || m_ready), "load over pending result")
    // A loaded result is offered in the next cycle
    `FCL_ASSERT_NEXT(a_load_then_valid, cmd.load, m_valid, "loaded result not offered")
    // Reads start and elements are written only on an accepted transaction
    `FCL_ASSERT_NOW(a_start_on_accept, (cmd.start || cmd.wr_en), (s_valid && s_ready),
                    "command without accepted transaction")
    // The input side stays closed while the MAC loop runs
    `FCL_ASSERT_NOW(a_busy_while_issue, cmd.issue, !s_ready, "ready during MAC loop")

endmodule

`default_nettype wire
